@@ sv/tsdq_pkg.sv @@
`timescale 1ns / 1ps

package tsdq_pkg;

  localparam int StackDepth = 256;
  localparam int DataWidth  = 32;
  localparam int PtrWidth   = $clog2(StackDepth);
  localparam int CntWidth   = PtrWidth + 1;
  localparam int PosWidth   = 9;
  localparam int CountWidth = 10;

  typedef enum logic [2:0] {
    OpPushFront = 3'd0,
    OpPushBack  = 3'd1,
    OpReadAt    = 3'd2,
    OpReadFront = 3'd3,
    OpReadBack  = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StRange = 2'd1,
    StEmpty = 2'd2,
    StFull  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SrcNone  = 2'd0,
    SrcFront = 2'd1,
    SrcBack  = 2'd2
  } rd_src_e;

endpackage

@@ sv/two_stack_deque_core.sv @@
`timescale 1ns / 1ps

// double-ended store built from two stacks held in synchronous memories.
// request channel: start with opcode_i, value_i and position_i is taken at
// any rising edge where start is high and busy is low. busy stays low, so a
// request may be issued every cycle.
// result channel: in the cycle after a request is taken, result_valid_o is high
// for exactly one cycle with read_data_o, status_o, element_count_o and
// is_empty_o. throughput is one request per cycle; the result comes from the
// registered read of the stack memories, whose address is formed from the
// request and the counts in the accept cycle.
// a push writes its memory at the accept edge, so a read issued in the next
// cycle already sees the new entry.
// the receiver cannot stall: every result is shown for one cycle only.
// reset (rst_ni low, asynchronous) empties both stacks by clearing their
// counts; memory contents are not cleared and need no clearing pass.
// status: ok, index out of range, empty store, or full stack (push dropped).
// read_data_o is zero for pushes and for every error.
module two_stack_deque_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       opcode_i,
  input  logic signed [tsdq_pkg::DataWidth-1:0] value_i,
  input  logic [tsdq_pkg::PosWidth-1:0]    position_i,
  output logic                             result_valid_o,
  output logic signed [tsdq_pkg::DataWidth-1:0] read_data_o,
  output logic [1:0]                       status_o,
  output logic [tsdq_pkg::CountWidth-1:0]  element_count_o,
  output logic                             is_empty_o
);
  import tsdq_pkg::*;

  logic [DataWidth-1:0] front_mem [StackDepth];
  logic [DataWidth-1:0] back_mem  [StackDepth];

  logic [CntWidth-1:0]   front_cnt_q, front_cnt_d;
  logic [CntWidth-1:0]   back_cnt_q, back_cnt_d;
  logic                  valid_q;
  status_e               status_q, status_d;
  rd_src_e               src_q, src_d;
  logic [DataWidth-1:0]  front_rdata_q, back_rdata_q;
  logic [PtrWidth-1:0]   front_raddr, back_raddr;
  logic                  front_we, back_we;
  logic                  accept;
  logic [CountWidth-1:0] total, pos_ext, fc_ext, front_idx, back_idx;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign fc_ext    = CountWidth'(front_cnt_q);
  assign total     = fc_ext + CountWidth'(back_cnt_q);
  assign pos_ext   = CountWidth'(position_i);
  assign front_idx = fc_ext - CountWidth'(1) - pos_ext;
  assign back_idx  = pos_ext - fc_ext;

  always_comb begin
    front_cnt_d = front_cnt_q;
    back_cnt_d  = back_cnt_q;
    status_d    = StOk;
    src_d       = SrcNone;
    front_we    = 1'b0;
    back_we     = 1'b0;
    front_raddr = front_cnt_q[PtrWidth-1:0] - PtrWidth'(1);
    back_raddr  = back_cnt_q[PtrWidth-1:0] - PtrWidth'(1);
    case (opcode_e'(opcode_i))
      OpPushFront: begin
        if (front_cnt_q >= CntWidth'(StackDepth)) begin
          status_d = StFull;
        end else begin
          front_we    = accept;
          front_cnt_d = front_cnt_q + CntWidth'(1);
        end
      end
      OpPushBack: begin
        if (back_cnt_q >= CntWidth'(StackDepth)) begin
          status_d = StFull;
        end else begin
          back_we    = accept;
          back_cnt_d = back_cnt_q + CntWidth'(1);
        end
      end
      OpReadAt: begin
        front_raddr = front_idx[PtrWidth-1:0];
        back_raddr  = back_idx[PtrWidth-1:0];
        if (pos_ext >= total) begin
          status_d = StRange;
        end else if (pos_ext < fc_ext) begin
          src_d = SrcFront;
        end else begin
          src_d = SrcBack;
        end
      end
      OpReadFront: begin
        back_raddr = '0;
        if (total == '0) begin
          status_d = StEmpty;
        end else if (front_cnt_q == '0) begin
          src_d = SrcBack;
        end else begin
          src_d = SrcFront;
        end
      end
      OpReadBack: begin
        front_raddr = '0;
        if (total == '0) begin
          status_d = StEmpty;
        end else if (back_cnt_q == '0) begin
          src_d = SrcFront;
        end else begin
          src_d = SrcBack;
        end
      end
      default: begin
        status_d = StOk;
      end
    endcase
  end

  // stack memories: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (front_we) begin
      front_mem[front_cnt_q[PtrWidth-1:0]] <= value_i;
    end
    front_rdata_q <= front_mem[front_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (back_we) begin
      back_mem[back_cnt_q[PtrWidth-1:0]] <= value_i;
    end
    back_rdata_q <= back_mem[back_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_cnt_q <= '0;
      back_cnt_q  <= '0;
      valid_q     <= 1'b0;
      status_q    <= StOk;
      src_q       <= SrcNone;
    end else begin
      valid_q <= accept;
      if (accept) begin
        front_cnt_q <= front_cnt_d;
        back_cnt_q  <= back_cnt_d;
        status_q    <= status_d;
        src_q       <= src_d;
      end
    end
  end

  always_comb begin
    case (src_q)
      SrcFront: read_data_o = front_rdata_q;
      SrcBack:  read_data_o = back_rdata_q;
      default:  read_data_o = '0;
    endcase
  end

  assign result_valid_o  = valid_q;
  assign status_o        = status_q;
  // counts already hold the value after the request shown
  assign element_count_o = total;
  assign is_empty_o      = (total == '0);

`ifndef SYNTHESIS
  a_result_follows_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("request without result");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !result_valid_o)
    else $error("result without request");

  a_full_push_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && opcode_i == OpPushFront && front_cnt_q == CntWidth'(StackDepth)
    |=> front_cnt_q == $past(front_cnt_q) && status_o == StFull)
    else $error("push into full front stack changed state");

  a_error_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != StOk |-> read_data_o == '0)
    else $error("error result carries data");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_cnt_q <= CntWidth'(StackDepth) && back_cnt_q <= CntWidth'(StackDepth))
    else $error("stack count beyond depth");
`endif

endmodule
